@@ hw/rtl/pcol_pkg.sv @@
// shared constants, register codes and types of the procedural pattern color block
package pcol_pkg;

   localparam int COORD_BITS      = 32;
   localparam int FRAC_BITS       = 16;
   localparam int CHAN_BITS       = 8;
   localparam int COLOR_BITS      = 3 * CHAN_BITS;
   localparam int MUL_BITS        = 2 * COORD_BITS;
   localparam int RAD_BITS        = MUL_BITS - 2 * FRAC_BITS;
   localparam int ROOT_BITS       = RAD_BITS / 2;
   localparam int STEPS_PER_STAGE = 4;
   localparam int SQRT_STAGES     = ROOT_BITS / STEPS_PER_STAGE;
   localparam int FIX_BITS        = FRAC_BITS + 1;
   localparam int PROD_BITS       = CHAN_BITS + FRAC_BITS;
   localparam int DATA_BITS       = 32;
   localparam int ADDR_BITS       = 4;
   localparam int REQ_DATA_BITS   = 3 * COORD_BITS;
   localparam int RSP_DATA_BITS   = COLOR_BITS;

   localparam logic [COLOR_BITS-1:0] FIRST_COLOR_RESET  = '1;
   localparam logic [COLOR_BITS-1:0] SECOND_COLOR_RESET = '0;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_KIND   = 2'd0;
   localparam logic [1:0] REG_FIRST  = 2'd1;
   localparam logic [1:0] REG_SECOND = 2'd2;

   typedef enum logic [1:0] {
      KIND_STRIPES   = 2'd0,
      KIND_GRADIENT  = 2'd1,
      KIND_RINGS     = 2'd2,
      KIND_CHECKERS  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [COLOR_BITS-1:0]   first_color;
      logic [COLOR_BITS-1:0]   second_color;
   } config_type;

   // per-request results that ride alongside the square root
   typedef struct packed {
      logic                    stripe;
      logic                    check;
      logic [COLOR_BITS-1:0]   grad;
   } side_type;

endpackage

@@ hw/rtl/procedural_pattern_color.sv @@
// Procedural pattern color: maps one pattern-space point (signed Q16.16 x, y, z) to an
// RGB888 color, choosing stripes, mirrored gradient, rings or checkers by the pattern
// kind register. The block takes one point per clock unless rsp_tready stalls it and
// returns results in order via four front stages (magnitudes; squares, rounding and the
// gradient fold; radius sum and channel products; gradient blend), four square-root
// stages of four root digits each, and the output register. Each stage has its own
// valid bit and only stalls when the stage after it is full, so a waiting result on
// rsp does not stop new requests while the pipeline has empty slots. Configuration is
// read live by the gradient product stage and the output color pick, so it must only
// change while the pipeline is empty.
module procedural_pattern_color (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: point_x [31:0], point_y [63:32], point_z [95:64]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pcol_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // result: red [7:0], green [15:8], blue [23:16]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pcol_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // configuration: pattern_kind at 0x0, first_color at 0x4, second_color at 0x8
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pcol_pkg::ADDR_BITS-1:0]       csr_paddr,
   input  logic [pcol_pkg::DATA_BITS-1:0]       csr_pwdata,
   output logic [pcol_pkg::DATA_BITS-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import pcol_pkg::*;

   localparam logic [COORD_BITS-1:0] ROUND_HALF = COORD_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [FIX_BITS-1:0]   FIX_ONE    = FIX_BITS'(1) << FRAC_BITS;

   config_type cfg;

   pcol_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---------------------------------------------------------------------------------
   // stage 1: coordinate magnitudes, stripe parity straight from the raw x bits
   // ---------------------------------------------------------------------------------
   logic                   s1_valid_ff, s1_valid_in, s1_ready;
   logic [COORD_BITS-1:0]  s1_mag_x_ff, s1_mag_x_in;
   logic [COORD_BITS-1:0]  s1_mag_y_ff, s1_mag_y_in;
   logic [COORD_BITS-1:0]  s1_mag_z_ff, s1_mag_z_in;
   logic                   s1_stripe_ff, s1_stripe_in;
   logic [COORD_BITS-1:0]  raw_x, raw_y, raw_z;

   logic s2_ready;

   assign raw_x = req_tdata[COORD_BITS-1:0];
   assign raw_y = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign raw_z = req_tdata[3*COORD_BITS-1:2*COORD_BITS];

   // the most negative value negates to 2^31, which still fits unsigned
   assign s1_mag_x_in  = raw_x[COORD_BITS-1] ? (~raw_x + COORD_BITS'(1)) : raw_x;
   assign s1_mag_y_in  = raw_y[COORD_BITS-1] ? (~raw_y + COORD_BITS'(1)) : raw_y;
   assign s1_mag_z_in  = raw_z[COORD_BITS-1] ? (~raw_z + COORD_BITS'(1)) : raw_z;
   assign s1_stripe_in = raw_x[FRAC_BITS];

   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign req_tready  = s1_ready;
   assign s1_valid_in = s1_ready ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) begin
         s1_mag_x_ff  <= s1_mag_x_in;
         s1_mag_y_ff  <= s1_mag_y_in;
         s1_mag_z_ff  <= s1_mag_z_in;
         s1_stripe_ff <= s1_stripe_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // stage 2: squares for the ring radius, checker parity, mirrored gradient fraction
   // ---------------------------------------------------------------------------------
   logic                   s2_valid_ff, s2_valid_in;
   logic [MUL_BITS-1:0]    s2_sq_x_ff, s2_sq_x_in;
   logic [MUL_BITS-1:0]    s2_sq_z_ff, s2_sq_z_in;
   logic [FIX_BITS-1:0]    s2_frac_ff, s2_frac_in;
   logic                   s2_check_ff, s2_check_in;
   logic                   s2_stripe_ff;
   logic [COORD_BITS-1:0]  round_x, round_y, round_z;
   logic [FIX_BITS-1:0]    frac_raw;

   logic s3_ready;

   assign s2_sq_x_in = MUL_BITS'(s1_mag_x_ff) * MUL_BITS'(s1_mag_x_ff);
   assign s2_sq_z_in = MUL_BITS'(s1_mag_z_ff) * MUL_BITS'(s1_mag_z_ff);

   // round half away from zero on magnitudes; only the parity of the sum matters
   assign round_x     = s1_mag_x_ff + ROUND_HALF;
   assign round_y     = s1_mag_y_ff + ROUND_HALF;
   assign round_z     = s1_mag_z_ff + ROUND_HALF;
   assign s2_check_in = round_x[FRAC_BITS] ^ round_y[FRAC_BITS] ^ round_z[FRAC_BITS];

   // |x| mod 2, folded back to 2 - f above one (two's complement of the low bits)
   assign frac_raw   = s1_mag_x_ff[FIX_BITS-1:0];
   assign s2_frac_in = (frac_raw > FIX_ONE) ? (~frac_raw + FIX_BITS'(1)) : frac_raw;

   assign s2_ready    = !s2_valid_ff || s3_ready;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_sq_x_ff   <= s2_sq_x_in;
         s2_sq_z_ff   <= s2_sq_z_in;
         s2_frac_ff   <= s2_frac_in;
         s2_check_ff  <= s2_check_in;
         s2_stripe_ff <= s1_stripe_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // stage 3: integer part of x^2 + z^2, gradient channel products
   // ---------------------------------------------------------------------------------
   logic                   s3_valid_ff, s3_valid_in;
   logic [RAD_BITS-1:0]    s3_rad_ff, s3_rad_in;
   logic [PROD_BITS-1:0]   s3_prod_a_ff [3];
   logic [PROD_BITS-1:0]   s3_prod_a_in [3];
   logic [PROD_BITS-1:0]   s3_prod_b_ff [3];
   logic [PROD_BITS-1:0]   s3_prod_b_in [3];
   logic                   s3_check_ff, s3_stripe_ff;
   logic [MUL_BITS-1:0]    sq_sum;
   logic [FIX_BITS-1:0]    frac_inv;

   logic s4_ready;

   // 2^62 + 2^62 at most, so the sum never carries out of 64 bits
   assign sq_sum    = s2_sq_x_ff + s2_sq_z_ff;
   assign s3_rad_in = sq_sum[MUL_BITS-1:2*FRAC_BITS];
   assign frac_inv  = FIX_ONE - s2_frac_ff;

   // channel k: blue is 0, red is 2, same packing as the color registers
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s3_prod_a_in[k] = PROD_BITS'(cfg.first_color[k*CHAN_BITS +: CHAN_BITS])
                         * PROD_BITS'(frac_inv);
         s3_prod_b_in[k] = PROD_BITS'(cfg.second_color[k*CHAN_BITS +: CHAN_BITS])
                         * PROD_BITS'(s2_frac_ff);
      end
   end

   assign s3_ready    = !s3_valid_ff || s4_ready;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_rad_ff    <= s3_rad_in;
         s3_prod_a_ff <= s3_prod_a_in;
         s3_prod_b_ff <= s3_prod_b_in;
         s3_check_ff  <= s2_check_ff;
         s3_stripe_ff <= s2_stripe_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // stage 4: gradient blend, truncated; square root starts from root 0, rem = radius
   // ---------------------------------------------------------------------------------
   logic                   s4_valid_ff, s4_valid_in;
   logic [RAD_BITS-1:0]    s4_rad_ff;
   side_type               s4_side_ff, s4_side_in;
   logic [PROD_BITS-1:0]   blend_sum [3];

   logic chain_ready [SQRT_STAGES+1];

   // the blend never exceeds max channel * one, so it fits without a carry
   always_comb begin
      s4_side_in.stripe = s3_stripe_ff;
      s4_side_in.check  = s3_check_ff;
      s4_side_in.grad   = '0;
      for (int k = 0; k < 3; k++) begin
         blend_sum[k] = s3_prod_a_ff[k] + s3_prod_b_ff[k];
         s4_side_in.grad[k*CHAN_BITS +: CHAN_BITS] = blend_sum[k][PROD_BITS-1:FRAC_BITS];
      end
   end

   assign s4_ready    = !s4_valid_ff || chain_ready[0];
   assign s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         s4_rad_ff  <= s3_rad_ff;
         s4_side_ff <= s4_side_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // stages 5 to 8: square root, most significant root digits first
   // ---------------------------------------------------------------------------------
   logic                   chain_valid [SQRT_STAGES+1];
   logic [RAD_BITS-1:0]    chain_rem   [SQRT_STAGES+1];
   logic [ROOT_BITS-1:0]   chain_root  [SQRT_STAGES+1];
   side_type               chain_side  [SQRT_STAGES+1];

   logic out_ready;

   assign chain_valid[0] = s4_valid_ff;
   assign chain_rem[0]   = s4_rad_ff;
   assign chain_root[0]  = '0;
   assign chain_side[0]  = s4_side_ff;

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
      pcol_sqrt_stage #(
         .STAGE (g)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_rem    (chain_rem[g]),
         .in_root   (chain_root[g]),
         .in_side   (chain_side[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_rem   (chain_rem[g+1]),
         .out_root  (chain_root[g+1]),
         .out_side  (chain_side[g+1])
      );
   end

   assign chain_ready[SQRT_STAGES] = out_ready;

   // ---------------------------------------------------------------------------------
   // stage 9: pick the color by pattern kind into the output register
   // ---------------------------------------------------------------------------------
   logic                   out_valid_ff, out_valid_in;
   logic [COLOR_BITS-1:0]  out_color_ff, out_color_in;
   side_type               last_side;
   logic                   ring_odd;

   assign last_side = chain_side[SQRT_STAGES];
   assign ring_odd  = chain_root[SQRT_STAGES][0];

   always_comb begin
      unique case (cfg.kind)
         KIND_STRIPES:  out_color_in = last_side.stripe ? cfg.first_color : cfg.second_color;
         KIND_GRADIENT: out_color_in = last_side.grad;
         KIND_RINGS:    out_color_in = ring_odd ? cfg.second_color : cfg.first_color;
         KIND_CHECKERS: out_color_in = last_side.check ? cfg.second_color : cfg.first_color;
         default:       out_color_in = cfg.first_color;
      endcase
   end

   assign out_ready    = !out_valid_ff || rsp_tready;
   assign out_valid_in = out_ready ? chain_valid[SQRT_STAGES] : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && chain_valid[SQRT_STAGES]) begin
         out_color_ff <= out_color_in;
      end
   end

   // color registers keep red on top; the stream carries red in the low byte
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_color_ff[CHAN_BITS-1:0],
                        out_color_ff[2*CHAN_BITS-1:CHAN_BITS],
                        out_color_ff[3*CHAN_BITS-1:2*CHAN_BITS]};

endmodule

@@ hw/rtl/pcol_csr.sv @@
// configuration registers behind the apb-style port
module pcol_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pcol_pkg::ADDR_BITS-1:0]    csr_paddr,
   input  logic [pcol_pkg::DATA_BITS-1:0]    csr_pwdata,
   output logic [pcol_pkg::DATA_BITS-1:0]    csr_prdata,
   output logic                              csr_pready,
   output pcol_pkg::config_type              cfg
);
   import pcol_pkg::*;

   kind_type               kind_ff, kind_in;
   logic [COLOR_BITS-1:0]  first_ff, first_in;
   logic [COLOR_BITS-1:0]  second_ff, second_in;
   logic                   wr_en;
   logic [1:0]             reg_idx;

   assign reg_idx    = csr_paddr[ADDR_BITS-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      kind_in   = kind_ff;
      first_in  = first_ff;
      second_in = second_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_KIND:   kind_in   = kind_type'(csr_pwdata[1:0]);
            REG_FIRST:  first_in  = csr_pwdata[COLOR_BITS-1:0];
            REG_SECOND: second_in = csr_pwdata[COLOR_BITS-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_STRIPES;
         first_ff  <= FIRST_COLOR_RESET;
         second_ff <= SECOND_COLOR_RESET;
      end else begin
         kind_ff   <= kind_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_KIND:   csr_prdata = DATA_BITS'(kind_ff);
         REG_FIRST:  csr_prdata = DATA_BITS'(first_ff);
         REG_SECOND: csr_prdata = DATA_BITS'(second_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.kind         = kind_ff;
   assign cfg.first_color  = first_ff;
   assign cfg.second_color = second_ff;

endmodule

@@ hw/rtl/pcol_sqrt_stage.sv @@
// one pipeline stage of the digit-by-digit integer square root
module pcol_sqrt_stage #(
   parameter int STAGE = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [pcol_pkg::RAD_BITS-1:0]     in_rem,
   input  logic [pcol_pkg::ROOT_BITS-1:0]    in_root,
   input  pcol_pkg::side_type                in_side,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [pcol_pkg::RAD_BITS-1:0]     out_rem,
   output logic [pcol_pkg::ROOT_BITS-1:0]    out_root,
   output pcol_pkg::side_type                out_side
);
   import pcol_pkg::*;

   logic                   valid_ff, valid_in;
   logic [RAD_BITS-1:0]    rem_ff, rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   side_type               side_ff;
   logic [RAD_BITS:0]      trial;

   // rem holds v - root^2; setting root bit p adds root*2^(p+1) + 2^(2p)
   always_comb begin
      rem_in  = in_rem;
      root_in = in_root;
      trial   = '0;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
         trial = ((RAD_BITS + 1)'(root_in) << (ROOT_BITS - STAGE * STEPS_PER_STAGE - j))
               + ((RAD_BITS + 1)'(1)
                  << (2 * (ROOT_BITS - 1 - STAGE * STEPS_PER_STAGE - j)));
         if ({1'b0, rem_in} >= trial) begin
            rem_in  = rem_in - trial[RAD_BITS-1:0];
            root_in = root_in
                    | (ROOT_BITS'(1) << (ROOT_BITS - 1 - STAGE * STEPS_PER_STAGE - j));
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

@@ hw/rtl/pcol_checker.sv @@
// port-level checks for the procedural pattern color block, bound to the top level
module pcol_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [pcol_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [pcol_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pcol_pkg::ADDR_BITS-1:0]       csr_paddr,
   input  logic [pcol_pkg::DATA_BITS-1:0]       csr_pwdata,
   input  logic [pcol_pkg::DATA_BITS-1:0]       csr_prdata,
   input  logic                                 csr_pready
);
   import pcol_pkg::*;

   logic wr_done;

   assign wr_done = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // a held result keeps its color
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // kind written then read back, only the low two bits kept
   a_kind_readback : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(wr_done && csr_paddr[ADDR_BITS-1:2] == REG_KIND)
      && csr_psel && !csr_pwrite && csr_paddr[ADDR_BITS-1:2] == REG_KIND
      |-> csr_prdata == DATA_BITS'($past(csr_pwdata[1:0])))
      else $error("pattern kind readback mismatch");

   // second color written then read back, upper byte dropped
   a_second_readback : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(wr_done && csr_paddr[ADDR_BITS-1:2] == REG_SECOND)
      && csr_psel && !csr_pwrite && csr_paddr[ADDR_BITS-1:2] == REG_SECOND
      |-> csr_prdata == DATA_BITS'($past(csr_pwdata[COLOR_BITS-1:0])))
      else $error("second color readback mismatch");

endmodule

bind procedural_pattern_color pcol_checker u_pcol_checker (.*);
